### rtl/core/mbcp_pkg.sv
`default_nettype none
package mbcp_pkg;

    localparam int unsigned PosW   = 16;
    localparam int unsigned DiffW  = PosW + 1;
    localparam int unsigned NumW   = 34;
    localparam int unsigned DenW   = 32;
    localparam int unsigned OffW   = 51;
    localparam int unsigned LimW   = DiffW + DenW;
    localparam int unsigned FrmW   = 24;
    localparam int unsigned FracSh = 6;
    localparam int unsigned DvdW   = NumW + FracSh;

    typedef struct packed {
        logic signed [PosW-1:0] own_x;
        logic signed [PosW-1:0] own_y;
        logic signed [PosW-1:0] vel_x;
        logic signed [PosW-1:0] vel_y;
        logic        [PosW-1:0] own_width;
        logic        [PosW-1:0] own_height;
        logic signed [PosW-1:0] target_x;
        logic signed [PosW-1:0] target_y;
        logic        [PosW-1:0] target_width;
        logic        [PosW-1:0] target_height;
    } t_box_pair;

    // state of one item inside the long-division chain
    typedef struct packed {
        logic            hit;
        logic            neg;
        logic            ovf;
        logic [DenW-1:0] den;
        logic [DvdW-1:0] rem;
        logic [FrmW-1:0] quo;
    } t_div_stage;

endpackage
`default_nettype wire

### rtl/core/mbcp_if.sv
`default_nettype none
interface mbcp_in_if
    import mbcp_pkg::*;
();
    logic      valid;
    logic      ready;
    logic signed [PosW-1:0] own_x;
    logic signed [PosW-1:0] own_y;
    logic signed [PosW-1:0] vel_x;
    logic signed [PosW-1:0] vel_y;
    logic        [PosW-1:0] own_width;
    logic        [PosW-1:0] own_height;
    logic signed [PosW-1:0] target_x;
    logic signed [PosW-1:0] target_y;
    logic        [PosW-1:0] target_width;
    logic        [PosW-1:0] target_height;

    modport source (output valid, own_x, own_y, vel_x, vel_y, own_width, own_height,
                    target_x, target_y, target_width, target_height, input ready);
    modport sink   (input valid, own_x, own_y, vel_x, vel_y, own_width, own_height,
                    target_x, target_y, target_width, target_height, output ready);
endinterface

interface mbcp_out_if
    import mbcp_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic                   will_hit;
    logic signed [FrmW-1:0] frames_to_hit;

    modport source (output valid, will_hit, frames_to_hit, input ready);
    modport sink   (input valid, will_hit, frames_to_hit, output ready);
endinterface
`default_nettype wire

### rtl/core/moving_box_collision_predict.sv
// moving box closest-approach collision predictor
// input channel i_in (sink): one moving box and one target box per beat
// output channel o_out (source): will_hit and frames_to_hit, one beat per input beat
// a beat is taken on any cycle where valid and ready are both high
// the path from input beat to output valid has five arithmetic
// stages (differences, products, num/den, cross products, overlap compare),
// 24 stages of restoring division (one quotient bit each) and an output register
// throughput is one beat per cycle; all stages advance together
// when the receiver stalls with a result waiting, the whole pipeline holds
// and i_in.ready drops; nothing is lost or repeated
// synchronous active-low reset clears all valid bits; payload is not reset
`default_nettype none
module moving_box_collision_predict
    import mbcp_pkg::*;
(
    input  wire          i_clk,
    input  wire          i_rst_n,
    mbcp_in_if.sink      i_in,
    mbcp_out_if.source   o_out
);

    logic w_en;

    // stage 1: differences and size sums
    logic                    r_v1;
    logic signed [DiffW-1:0] r_ex, r_ey;
    logic signed [PosW-1:0]  r_vx1, r_vy1;
    logic        [DiffW-1:0] r_sx1, r_sy1;
    logic                    r_still1;

    // stage 2: products
    logic                    r_v2;
    logic signed [DiffW+PosW-1:0] r_pxa, r_pya;
    logic        [DenW-1:0]  r_pvx, r_pvy;
    logic signed [DiffW-1:0] r_ex2, r_ey2;
    logic signed [PosW-1:0]  r_vx2, r_vy2;
    logic        [DiffW-1:0] r_sx2, r_sy2;
    logic                    r_still2;

    // stage 3: num and den
    logic                    r_v3;
    logic signed [NumW-1:0]  r_num3;
    logic        [DenW-1:0]  r_den3;
    logic signed [DiffW-1:0] r_ex3, r_ey3;
    logic signed [PosW-1:0]  r_vx3, r_vy3;
    logic        [DiffW-1:0] r_sx3, r_sy3;

    // stage 4: cross products
    logic                    r_v4;
    logic signed [OffW-2:0]  r_qx1, r_qx2, r_qy1, r_qy2;
    logic        [LimW-1:0]  r_lx, r_ly;
    logic signed [NumW-1:0]  r_num4;
    logic        [DenW-1:0]  r_den4;

    // division chain, entry 0 is stage 5
    logic       r_dv [0:FrmW];
    t_div_stage r_dd [0:FrmW];
    t_div_stage n_dd [0:FrmW];

    logic                   r_ov;
    logic                   r_ohit;
    logic signed [FrmW-1:0] r_ofrm;

    assign w_en       = !r_ov || o_out.ready;
    assign i_in.ready = w_en;

    logic signed [OffW-1:0]  w_offx, w_offy;
    logic        [OffW:0]    w_ax, w_ay;
    logic                    w_hit;
    logic        [NumW-1:0]  w_anum;
    logic        [DvdW-1:0]  w_dvd;
    logic                    w_ovf;
    logic        [FrmW-1:0]  w_q;
    logic signed [FrmW-1:0]  n_ofrm;

    always_comb begin
        w_offx = OffW'(r_qx1) + OffW'(r_qx2);
        w_offy = OffW'(r_qy1) + OffW'(r_qy2);
        w_ax   = w_offx[OffW-1] ? (OffW+1)'(-w_offx) : (OffW+1)'(w_offx);
        w_ay   = w_offy[OffW-1] ? (OffW+1)'(-w_offy) : (OffW+1)'(w_offy);
        w_hit  = ({w_ax, 1'b0} < (OffW+2)'(r_lx)) && ({w_ay, 1'b0} < (OffW+2)'(r_ly));
        w_anum = r_num4[NumW-1] ? NumW'(-r_num4) : NumW'(r_num4);
        w_dvd  = {w_anum, {FracSh{1'b0}}};
        w_ovf  = (DenW+FrmW)'(w_dvd) >= {r_den4, {FrmW{1'b0}}};
    end

    always_comb begin
        n_dd[0].hit = w_hit;
        n_dd[0].neg = r_num4[NumW-1];
        n_dd[0].ovf = w_ovf;
        n_dd[0].den = r_den4;
        n_dd[0].rem = w_dvd;
        n_dd[0].quo = '0;
        // one quotient bit per stage, msb first
        for (int k = 1; k <= FrmW; k++) begin
            n_dd[k] = r_dd[k-1];
            if ((DenW+FrmW)'(r_dd[k-1].rem)
                    >= ((DenW+FrmW)'(r_dd[k-1].den) << (FrmW-k))) begin
                n_dd[k].rem = DvdW'((DenW+FrmW)'(r_dd[k-1].rem)
                              - ((DenW+FrmW)'(r_dd[k-1].den) << (FrmW-k)));
                n_dd[k].quo[FrmW-k] = 1'b1;
            end
        end
    end

    always_comb begin
        w_q = r_dd[FrmW].quo;
        if (!r_dd[FrmW].hit) begin
            n_ofrm = '0;
        end else if (!r_dd[FrmW].neg) begin
            if (r_dd[FrmW].ovf || w_q[FrmW-1]) n_ofrm = {1'b0, {(FrmW-1){1'b1}}};
            else                               n_ofrm = $signed(w_q);
        end else begin
            if (r_dd[FrmW].ovf || (w_q > {1'b1, {(FrmW-1){1'b0}}}))
                n_ofrm = {1'b1, {(FrmW-1){1'b0}}};
            else
                n_ofrm = $signed(-w_q);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ex     <= DiffW'(i_in.own_x) - DiffW'(i_in.target_x);
            r_ey     <= DiffW'(i_in.own_y) - DiffW'(i_in.target_y);
            r_vx1    <= i_in.vel_x;
            r_vy1    <= i_in.vel_y;
            r_sx1    <= DiffW'(i_in.own_width) + DiffW'(i_in.target_width);
            r_sy1    <= DiffW'(i_in.own_height) + DiffW'(i_in.target_height);
            r_still1 <= (i_in.vel_x == '0) && (i_in.vel_y == '0);

            r_pxa    <= r_ex * r_vx1;
            r_pya    <= r_ey * r_vy1;
            r_pvx    <= DenW'(r_vx1 * r_vx1);
            r_pvy    <= DenW'(r_vy1 * r_vy1);
            r_ex2    <= r_ex;
            r_ey2    <= r_ey;
            r_vx2    <= r_vx1;
            r_vy2    <= r_vy1;
            r_sx2    <= r_sx1;
            r_sy2    <= r_sy1;
            r_still2 <= r_still1;

            // num is (t - own) . v, so it is the negated sum of (own - t) * v
            r_num3 <= r_still2 ? '0 : -(NumW'(r_pxa) + NumW'(r_pya));
            r_den3 <= r_still2 ? DenW'(1) : r_pvx + r_pvy;
            r_ex3  <= r_ex2;
            r_ey3  <= r_ey2;
            r_vx3  <= r_vx2;
            r_vy3  <= r_vy2;
            r_sx3  <= r_sx2;
            r_sy3  <= r_sy2;

            r_qx1  <= (OffW-1)'(r_ex3 * $signed({1'b0, r_den3}));
            r_qy1  <= (OffW-1)'(r_ey3 * $signed({1'b0, r_den3}));
            r_qx2  <= (OffW-1)'(r_vx3 * r_num3);
            r_qy2  <= (OffW-1)'(r_vy3 * r_num3);
            r_lx   <= LimW'(r_sx3) * LimW'(r_den3);
            r_ly   <= LimW'(r_sy3) * LimW'(r_den3);
            r_num4 <= r_num3;
            r_den4 <= r_den3;

            for (int k = 0; k <= FrmW; k++) r_dd[k] <= n_dd[k];

            r_ohit <= r_dd[FrmW].hit;
            r_ofrm <= n_ofrm;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_ov <= 1'b0;
            for (int k = 0; k <= FrmW; k++) r_dv[k] <= 1'b0;
        end else if (w_en) begin
            r_v1    <= i_in.valid;
            r_v2    <= r_v1;
            r_v3    <= r_v2;
            r_v4    <= r_v3;
            r_dv[0] <= r_v4;
            for (int k = 1; k <= FrmW; k++) r_dv[k] <= r_dv[k-1];
            r_ov    <= r_dv[FrmW];
        end
    end

    assign o_out.valid         = r_ov;
    assign o_out.will_hit      = r_ohit;
    assign o_out.frames_to_hit = r_ofrm;

endmodule
`default_nettype wire

### rtl/core/mbcp_chk.sv
`default_nettype none
module mbcp_chk
    import mbcp_pkg::*;
(
    input wire            i_clk,
    input wire            i_rst_n,
    input wire            i_in_ready,
    input wire            i_out_valid,
    input wire            i_out_ready,
    input wire            i_will_hit,
    input wire [FrmW-1:0] i_frames
);

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_will_hit) |-> (i_frames == '0))
        else $error("frames nonzero on a miss");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |-> !i_in_ready)
        else $error("input taken while output stalled");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_will_hit)
                                            && $stable(i_frames)))
        else $error("stalled result changed");

endmodule

bind moving_box_collision_predict mbcp_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_will_hit  (o_out.will_hit),
    .i_frames    (o_out.frames_to_hit)
);
`default_nettype wire

### verif/moving_box_collision_predict_tb.sv
`timescale 1ns / 1ps
`default_nettype none
module moving_box_collision_predict_tb;
    import mbcp_pkg::*;

    typedef struct packed {
        logic                   will_hit;
        logic signed [FrmW-1:0] frames_to_hit;
    } t_hit_result;

    // predicted results for boxes already accepted, oldest first
    class hit_scoreboard;
        t_hit_result pending[$];
        int          n_mismatch;

        function automatic longint absval(longint v);
            return v < 0 ? -v : v;
        endfunction

        function automatic t_hit_result predict(t_box_pair p);
            longint x, y, vx, vy, tx, ty, sw, sh, num, den, offx, offy, frm;
            t_hit_result r;
            x = p.own_x; y = p.own_y; vx = p.vel_x; vy = p.vel_y;
            tx = p.target_x; ty = p.target_y;
            sw = longint'(p.own_width) + longint'(p.target_width);
            sh = longint'(p.own_height) + longint'(p.target_height);
            if (vx == 0 && vy == 0) begin
                num = 0;
                den = 1;
            end else begin
                num = (tx - x) * vx + (ty - y) * vy;
                den = vx * vx + vy * vy;
            end
            offx = (x - tx) * den + vx * num;
            offy = (y - ty) * den + vy * num;
            r.will_hit = (2 * absval(offx) < sw * den) && (2 * absval(offy) < sh * den);
            frm = 0;
            if (r.will_hit) begin
                // integer division truncates toward zero
                frm = (num * 64) / den;
                if (frm > 8388607) frm = 8388607;
                if (frm < -8388608) frm = -8388608;
            end
            r.frames_to_hit = frm[FrmW-1:0];
            return r;
        endfunction

        function void note_box(t_box_pair p);
            pending.push_back(predict(p));
        endfunction

        function void check_result(logic hit, logic [FrmW-1:0] frm);
            t_hit_result e;
            if (pending.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10) $display("unexpected result hit=%0d frames=%0d", hit,
                    $signed(frm));
                return;
            end
            e = pending.pop_front();
            if (e.will_hit !== hit || e.frames_to_hit !== frm) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("mismatch: exp hit=%0d frames=%0d, got hit=%0d frames=%0d",
                        e.will_hit, e.frames_to_hit, hit, $signed(frm));
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    mbcp_in_if  in_ch();
    mbcp_out_if out_ch();

    moving_box_collision_predict i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    hit_scoreboard sb;
    int     send_idle_pct;
    int     recv_stall_pct;
    longint n_cycles = 0;
    bit     timed_out = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // receiver side and result check
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready)
            sb.check_result(out_ch.will_hit, out_ch.frames_to_hit);
        if (recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= 1'b1;
    end

    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > 400000 && !timed_out) begin
            timed_out = 1'b1;
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic logic [15:0] rnd_pos();
        case ($urandom_range(3))
            0: return 16'($urandom);
            1: return 16'($signed($urandom_range(0, 2047)) - 1024);
            2: return 16'($signed($urandom_range(0, 255)) - 128);
            default: return 16'($urandom_range(1) ? 16'h7fff : 16'h8000);
        endcase
    endfunction

    function automatic t_box_pair rnd_pair();
        t_box_pair p;
        p.own_x = rnd_pos();
        p.own_y = rnd_pos();
        p.vel_x = $urandom_range(9) == 0 ? 16'sd0 : rnd_pos();
        p.vel_y = $urandom_range(9) == 0 ? 16'sd0 : rnd_pos();
        p.own_width = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(4096));
        p.own_height = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(4096));
        // keep the target close most of the time so hits are common
        if ($urandom_range(3) != 0) begin
            p.target_x = p.own_x + 16'($signed($urandom_range(0, 4095)) - 2048);
            p.target_y = p.own_y + 16'($signed($urandom_range(0, 4095)) - 2048);
        end else begin
            p.target_x = rnd_pos();
            p.target_y = rnd_pos();
        end
        p.target_width = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(4096));
        p.target_height = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(4096));
        return p;
    endfunction

    function automatic t_box_pair mk(int x, int y, int vx, int vy, int w, int h,
                                     int tx, int ty, int tw, int tht);
        t_box_pair p;
        p.own_x = 16'(x); p.own_y = 16'(y); p.vel_x = 16'(vx); p.vel_y = 16'(vy);
        p.own_width = 16'(w); p.own_height = 16'(h);
        p.target_x = 16'(tx); p.target_y = 16'(ty);
        p.target_width = 16'(tw); p.target_height = 16'(tht);
        return p;
    endfunction

    task automatic send_box(t_box_pair p);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.own_x <= p.own_x; in_ch.own_y <= p.own_y;
        in_ch.vel_x <= p.vel_x; in_ch.vel_y <= p.vel_y;
        in_ch.own_width <= p.own_width; in_ch.own_height <= p.own_height;
        in_ch.target_x <= p.target_x; in_ch.target_y <= p.target_y;
        in_ch.target_width <= p.target_width; in_ch.target_height <= p.target_height;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_box(p);
    endtask

    task automatic run_phase(int idle, int stall, int count);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        repeat (count) send_box(rnd_pair());
    endtask

    initial begin
        t_box_pair dir[$];
        sb = new();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.own_x = '0; in_ch.own_y = '0; in_ch.vel_x = '0; in_ch.vel_y = '0;
        in_ch.own_width = '0; in_ch.own_height = '0;
        in_ch.target_x = '0; in_ch.target_y = '0;
        in_ch.target_width = '0; in_ch.target_height = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // standing box, overlapping and apart
        dir.push_back(mk(0, 0, 0, 0, 64, 64, 10, 10, 64, 64));
        dir.push_back(mk(0, 0, 0, 0, 64, 64, 500, 0, 64, 64));
        // touching edges do not count
        dir.push_back(mk(0, 0, 0, 0, 64, 64, 64, 0, 64, 64));
        dir.push_back(mk(0, 0, 0, 0, 64, 64, 63, 0, 64, 64));
        // target ahead and behind
        dir.push_back(mk(0, 0, 64, 0, 64, 64, 6400, 0, 64, 64));
        dir.push_back(mk(0, 0, 64, 0, 64, 64, -6400, 0, 64, 64));
        dir.push_back(mk(0, 0, 3, 7, 100, 100, 321, -55, 300, 300));
        // tiny velocity with the target far ahead and far behind
        dir.push_back(mk(-32768, -32768, 1, 1, 65535, 65535, 32767, 32767, 65535, 65535));
        dir.push_back(mk(32767, 32767, 1, 1, 65535, 65535, -32768, -32768, 65535, 65535));
        dir.push_back(mk(32767, -32768, -32768, 32767, 65535, 0, -32768, 32767, 65535, 65535));
        dir.push_back(mk(-32768, 32767, 32767, -32768, 0, 65535, 32767, -32768, 65535, 0));
        dir.push_back(mk(0, 0, -32768, -32768, 0, 0, 0, 0, 0, 0));
        dir.push_back(mk(0, 0, 32767, 32767, 65535, 65535, 0, 0, 65535, 65535));
        dir.push_back(mk(-1, -1, -1, -1, 65535, 65535, -1, -1, 1, 1));
        dir.push_back(mk(0, 0, 0, -5, 10, 10, 3, -90, 1, 1));
        foreach (dir[k]) send_box(dir[k]);

        run_phase(0, 0, 190);
        run_phase(80, 0, 180);
        run_phase(0, 80, 180);
        run_phase(22, 22, 200);
        send_idle_pct = 0;
        in_ch.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (sb.n_mismatch == 0 && sb.pending.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
`default_nettype wire

### filelist.f
rtl/core/mbcp_pkg.sv
rtl/core/mbcp_if.sv
rtl/core/moving_box_collision_predict.sv
rtl/core/mbcp_chk.sv
verif/moving_box_collision_predict_tb.sv
